FILE: hdl/svfp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sampled values frame parser package
// Shared types, event codes, BER tags and sizing constants.
// ----------------------------------------------------------------------------
package svfp_pkg;

  localparam int SVFP_MAX_PAYLOAD_BYTES = 2048;
  localparam int SVFP_MAX_EVENTS        = 6;
  localparam int SVFP_Q_DEPTH           = 2;

  localparam logic [7:0]  SVFP_CAP_DEFAULT = 8'd200;
  localparam logic [29:0] SVFP_NS_PER_S    = 30'd1000000000;

  typedef enum logic [3:0] {
    PH_HEADER  = 4'd0,
    PH_ALEN    = 4'd1,
    PH_TAG     = 4'd2,
    PH_LEN1    = 4'd3,
    PH_LENX    = 4'd4,
    PH_CONTENT = 4'd5,
    PH_SKIP    = 4'd6,
    PH_AFTER   = 4'd7,
    PH_REJECT  = 4'd8
  } phase_t;

  localparam logic [4:0] K_APPID     = 5'd0;
  localparam logic [4:0] K_LENGTH    = 5'd1;
  localparam logic [4:0] K_SIM       = 5'd2;
  localparam logic [4:0] K_REJECT    = 5'd3;
  localparam logic [4:0] K_IMPLAUS   = 5'd4;
  localparam logic [4:0] K_TRUNC     = 5'd5;
  localparam logic [4:0] K_NOASDU    = 5'd6;
  localparam logic [4:0] K_ASDU      = 5'd7;
  localparam logic [4:0] K_SVID      = 5'd8;
  localparam logic [4:0] K_DATSET    = 5'd9;
  localparam logic [4:0] K_SMPCNT    = 5'd10;
  localparam logic [4:0] K_CONFREV   = 5'd11;
  localparam logic [4:0] K_SECONDS   = 5'd12;
  localparam logic [4:0] K_NSEC      = 5'd13;
  localparam logic [4:0] K_QUALITY   = 5'd14;
  localparam logic [4:0] K_SMPSYNCH  = 5'd15;
  localparam logic [4:0] K_SMPRATE   = 5'd16;
  localparam logic [4:0] K_SEQDATA   = 5'd17;
  localparam logic [4:0] K_SMPMOD    = 5'd18;
  localparam logic [4:0] K_GMID      = 5'd19;
  localparam logic [4:0] K_BADLEN    = 5'd20;
  localparam logic [4:0] K_OVERRUN   = 5'd21;
  localparam logic [4:0] K_BADINT    = 5'd22;
  localparam logic [4:0] K_BADREFR   = 5'd23;
  localparam logic [4:0] K_UNKPDU    = 5'd24;
  localparam logic [4:0] K_NOTSEQ    = 5'd25;
  localparam logic [4:0] K_CAP       = 5'd26;
  localparam logic [4:0] K_MISMATCH  = 5'd27;
  localparam logic [4:0] K_BADGMID   = 5'd28;
  localparam logic [4:0] K_UNKASDU   = 5'd29;
  localparam logic [4:0] K_END       = 5'd30;

  localparam logic [63:0] RJ_SHORT_PAYLOAD = 64'd1;
  localparam logic [63:0] RJ_SHORT_REGION  = 64'd2;
  localparam logic [63:0] RJ_BAD_TAG       = 64'd3;
  localparam logic [63:0] RJ_BAD_LENFORM   = 64'd4;
  localparam logic [63:0] RJ_LEN_OVERRUN   = 64'd5;
  localparam logic [63:0] RJ_EARLY_END     = 64'd6;

  localparam logic [7:0] TAG_APDU     = 8'h60;
  localparam logic [7:0] TAG_ASDU     = 8'h30;
  localparam logic [7:0] TAG_SEQASDU  = 8'hA2;
  localparam logic [7:0] TAG_NOASDU   = 8'h80;
  localparam logic [7:0] TAG_SVID     = 8'h80;
  localparam logic [7:0] TAG_DATSET   = 8'h81;
  localparam logic [7:0] TAG_SMPCNT   = 8'h82;
  localparam logic [7:0] TAG_CONFREV  = 8'h83;
  localparam logic [7:0] TAG_REFRTM   = 8'h84;
  localparam logic [7:0] TAG_SMPSYNCH = 8'h85;
  localparam logic [7:0] TAG_SMPRATE  = 8'h86;
  localparam logic [7:0] TAG_SEQDATA  = 8'h87;
  localparam logic [7:0] TAG_SMPMOD   = 8'h88;
  localparam logic [7:0] TAG_GMID     = 8'h89;

  typedef struct packed {
    logic [4:0]  kind;
    logic [7:0]  asdu;
    logic [7:0]  tag;
    logic [63:0] value;
    logic [31:0] flen;
    logic        last;
  } event_t;

  typedef struct packed {
    logic [2:0]                       count;
    event_t [SVFP_MAX_EVENTS-1:0]     ev;
  } step_t;

  typedef struct packed {
    logic  valid;
    step_t head;
  } q_head_t;

  function automatic logic is_int_tag(input logic [7:0] t);
    return t == TAG_SMPCNT || t == TAG_CONFREV || t == TAG_SMPSYNCH ||
           t == TAG_SMPRATE || t == TAG_SMPMOD;
  endfunction

endpackage

FILE: hdl/sampled_values_frame_parser_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sampled values frame parser
// Streaming decoder of sampled values Ethernet payloads into event items.
// ----------------------------------------------------------------------------
// Usage:
//   Input is a queue: drive in_payload_byte, in_payload_length and
//   in_last_byte with in_push; a byte is taken when in_full is low.
//   Results are a queue: while out_empty is low the oldest event item sits
//   on the out_ ports; out_pop takes it. out_last_result marks the last
//   item caused by one byte.
//   cfg_we with cfg_wdata writes the ASDU cap (0 acts as 200); write only
//   while the block is idle.
//   Throughput: one byte per cycle, set by the combinational parse step in
//   the front end; results leave one per cycle while out_pop is held, so
//   bytes that cause several items stall input once the two-entry step
//   queue fills. The first item of a byte goes through the step queue and
//   then the result register before it shows on the out_ ports.
//   Reset (rst_n low, synchronous) empties both queues and returns the
//   parser to the header state with the cap at 200. A stalled receiver
//   holds its item; in_full rises when the step queue is full.
// ----------------------------------------------------------------------------
module sampled_values_frame_parser_unit #(
  parameter int MAX_PAYLOAD_BYTES = svfp_pkg::SVFP_MAX_PAYLOAD_BYTES
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  input  logic        in_push,
  output logic        in_full,
  input  logic [7:0]  in_payload_byte,
  input  logic [11:0] in_payload_length,
  input  logic        in_last_byte,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [4:0]  out_event_kind,
  output logic [7:0]  out_asdu_index,
  output logic [7:0]  out_field_tag,
  output logic [63:0] out_value,
  output logic [31:0] out_field_length,
  output logic        out_last_result
);
  import svfp_pkg::*;

  logic    accept, step_valid, q_pop;
  step_t   step;
  q_head_t head;
  event_t  oev;

  assign accept = in_push && !in_full;

  svfp_front #(
    .MAX_PAYLOAD_BYTES(MAX_PAYLOAD_BYTES)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .accept     (accept),
    .byte_in    (in_payload_byte),
    .plen_in    (in_payload_length),
    .last_in    (in_last_byte),
    .step_valid (step_valid),
    .step       (step)
  );

  svfp_step_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (step_valid),
    .wdata (step),
    .pop   (q_pop),
    .full  (in_full),
    .head  (head)
  );

  svfp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .q_pop     (q_pop),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_ev    (oev)
  );

  assign out_event_kind   = oev.kind;
  assign out_asdu_index   = oev.asdu;
  assign out_field_tag    = oev.tag;
  assign out_value        = oev.value;
  assign out_field_length = oev.flen;
  assign out_last_result  = oev.last;

endmodule

FILE: hdl/svfp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sampled values frame parser front end
// Header and BER walk, one byte per cycle while accept is high; gathers the events of each byte.
// ----------------------------------------------------------------------------
module svfp_front #(
  parameter int MAX_PAYLOAD_BYTES = svfp_pkg::SVFP_MAX_PAYLOAD_BYTES
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [7:0]          cfg_wdata,
  input  logic                accept,
  input  logic [7:0]          byte_in,
  input  logic [11:0]         plen_in,
  input  logic                last_in,
  output logic                step_valid,
  output svfp_pkg::step_t     step
);
  import svfp_pkg::*;

  localparam logic [15:0] MaxPl = 16'(MAX_PAYLOAD_BYTES);

  phase_t      ph_r, ph;
  logic [15:0] pos_r, pos, dl_r, dl, re_r, re, appid_r, appid, aend_r, aend;
  logic [31:0] rem_r [4];
  logic [31:0] rem   [4];
  logic [7:0]  tags_r [3];
  logic [7:0]  tags   [3];
  logic [31:0] lacc_r, lacc;
  logic [2:0]  lbl_r, lbl;
  logic [63:0] iacc_r, iacc;
  logic [7:0]  acnt_r, acnt;
  logic [63:0] dac_r, dac;
  logic        sim_r, sim, impl_r, impl;
  logic [1:0]  lvl_r, lvl;
  logic [7:0]  max_asdus_r;

  event_t [SVFP_MAX_EVENTS-1:0] evs;
  logic [2:0]  ev_n;
  logic [7:0]  capv, tag;
  logic [6:0]  nlen;
  logic [31:0] present, eff;
  logic [63:0] v, trail;
  logic        acc_go, body_go, hd, ld, sdone;

  function automatic event_t mk_ev(input logic [4:0] k, input logic [7:0] a,
                                   input logic [7:0] t, input logic [63:0] val,
                                   input logic [31:0] fl);
    event_t e;
    e.kind  = k;
    e.asdu  = a;
    e.tag   = t;
    e.value = val;
    e.flen  = fl;
    e.last  = 1'b0;
    return e;
  endfunction

  function automatic logic [6:0] in_n7(input logic [7:0] b);
    return b[6:0];
  endfunction

  always_comb begin
    ph = ph_r; pos = pos_r; dl = dl_r; re = re_r; appid = appid_r; aend = aend_r;
    rem = rem_r; tags = tags_r; lacc = lacc_r; lbl = lbl_r; iacc = iacc_r;
    acnt = acnt_r; dac = dac_r; sim = sim_r; impl = impl_r; lvl = lvl_r;
    evs = '0; ev_n = 3'd0;
    acc_go = 1'b0; body_go = 1'b0; hd = 1'b0; ld = 1'b0; sdone = 1'b0;
    nlen = in_n7(byte_in);
    present = '0; eff = '0; v = '0; trail = '0; tag = '0;
    capv = (max_asdus_r == 8'd0) ? SVFP_CAP_DEFAULT : max_asdus_r;

    if (ph == PH_HEADER || ph == PH_ALEN) begin
      if (ph == PH_ALEN) begin
        lacc = {lacc[23:0], byte_in};
        if (lbl != 3'd0) lbl = lbl - 3'd1;
        if (lbl == 3'd0) acc_go = 1'b1;
      end else begin
        case (pos)
          16'd0: begin
            re    = ({4'd0, plen_in} > MaxPl) ? MaxPl : {4'd0, plen_in};
            appid = {byte_in, 8'h00};
            if (re < 16'd10) begin
              if (ev_n < 3'd6) begin
                evs[ev_n] = mk_ev(K_REJECT, acnt, 8'h00, RJ_SHORT_PAYLOAD, 32'd0);
                ev_n = ev_n + 3'd1;
              end
              ph = PH_REJECT;
            end
          end
          16'd1: appid[7:0] = byte_in;
          16'd2: dl = {byte_in, 8'h00};
          16'd3: begin
            dl[7:0] = byte_in;
            if (dl >= 16'd8 && dl <= re) re = dl;
            else impl = 1'b1;
            if (re < 16'd10) begin
              if (ev_n < 3'd6) begin
                evs[ev_n] = mk_ev(K_REJECT, acnt, 8'h00, RJ_SHORT_REGION, 32'd0);
                ev_n = ev_n + 3'd1;
              end
              ph = PH_REJECT;
            end
          end
          16'd4: sim = byte_in[7];
          16'd8: begin
            if (byte_in != TAG_APDU) begin
              if (ev_n < 3'd6) begin
                evs[ev_n] = mk_ev(K_REJECT, acnt, 8'h00, RJ_BAD_TAG, 32'd0);
                ev_n = ev_n + 3'd1;
              end
              ph = PH_REJECT;
            end
          end
          16'd9: begin
            if (!byte_in[7]) begin
              lacc   = {24'd0, byte_in};
              acc_go = 1'b1;
            end else if (nlen == 7'd0 || nlen > 7'd4) begin
              if (ev_n < 3'd6) begin
                evs[ev_n] = mk_ev(K_REJECT, acnt, 8'h00, RJ_BAD_LENFORM, 32'd0);
                ev_n = ev_n + 3'd1;
              end
              ph = PH_REJECT;
            end else if ({9'd0, nlen} > re - 16'd10) begin
              if (ev_n < 3'd6) begin
                evs[ev_n] = mk_ev(K_REJECT, acnt, 8'h00, RJ_LEN_OVERRUN, 32'd0);
                ev_n = ev_n + 3'd1;
              end
              ph = PH_REJECT;
            end else begin
              lacc = '0;
              lbl  = nlen[2:0];
              ph   = PH_ALEN;
            end
          end
          default: ;
        endcase
      end
      if (acc_go) begin
        present = {16'd0, re} - ({16'd0, pos} + 32'd1);
        eff     = (lacc < present) ? lacc : present;
        if (ev_n < 3'd6) begin
          evs[ev_n] = mk_ev(K_APPID, acnt, 8'h00, {48'd0, appid}, 32'd0);
          ev_n = ev_n + 3'd1;
        end
        if (ev_n < 3'd6) begin
          evs[ev_n] = mk_ev(K_LENGTH, acnt, 8'h00, {48'd0, dl}, 32'd0);
          ev_n = ev_n + 3'd1;
        end
        if (ev_n < 3'd6) begin
          evs[ev_n] = mk_ev(K_SIM, acnt, 8'h00, {63'd0, sim}, 32'd0);
          ev_n = ev_n + 3'd1;
        end
        if (impl && ev_n < 3'd6) begin
          evs[ev_n] = mk_ev(K_IMPLAUS, acnt, 8'h00, {48'd0, dl}, {16'd0, re});
          ev_n = ev_n + 3'd1;
        end
        if (eff < lacc && ev_n < 3'd6) begin
          evs[ev_n] = mk_ev(K_TRUNC, acnt, TAG_APDU, {32'd0, present}, lacc);
          ev_n = ev_n + 3'd1;
        end
        rem[0] = eff;
        aend   = pos + 16'd1 + eff[15:0];
        lvl    = 2'd0;
        ph     = PH_TAG;
      end
    end else if (ph == PH_TAG || ph == PH_LEN1 || ph == PH_LENX ||
                 ph == PH_CONTENT || ph == PH_SKIP) begin
      body_go = 1'b1;
      for (int k = 0; k < 3; k++) begin
        if (k <= int'(lvl) && rem[k] != 32'd0) rem[k] = rem[k] - 32'd1;
      end
      case (ph)
        PH_TAG: begin
          tags[lvl] = byte_in;
          ph        = PH_LEN1;
        end
        PH_LEN1: begin
          if (!byte_in[7]) begin
            lacc = {24'd0, byte_in};
            hd   = 1'b1;
          end else if (nlen == 7'd0 || nlen > 7'd4 || {25'd0, nlen} > rem[lvl]) begin
            if (ev_n < 3'd6) begin
              evs[ev_n] = mk_ev(K_BADLEN, acnt, tags[lvl], {62'd0, lvl}, 32'd0);
              ev_n = ev_n + 3'd1;
            end
            ph = PH_SKIP;
          end else begin
            lacc = '0;
            lbl  = nlen[2:0];
            ph   = PH_LENX;
          end
        end
        PH_LENX: begin
          lacc = {lacc[23:0], byte_in};
          if (lbl != 3'd0) lbl = lbl - 3'd1;
          if (lbl == 3'd0) hd = 1'b1;
        end
        PH_CONTENT: begin
          if (rem[lvl + 2'd1] != 32'd0) rem[lvl + 2'd1] = rem[lvl + 2'd1] - 32'd1;
          tag = tags[lvl];
          if (lvl == 2'd0 && tag == TAG_NOASDU) begin
            iacc = {iacc[55:0], byte_in};
          end else if (lvl == 2'd2) begin
            if (tag == TAG_SVID || tag == TAG_DATSET || tag == TAG_SEQDATA ||
                tag == TAG_GMID) begin
              if (ev_n < 3'd6) begin
                evs[ev_n] = mk_ev((tag == TAG_SVID) ? K_SVID :
                                  (tag == TAG_DATSET) ? K_DATSET :
                                  (tag == TAG_SEQDATA) ? K_SEQDATA : K_GMID,
                                  acnt, tag, {56'd0, byte_in}, lacc);
                ev_n = ev_n + 3'd1;
              end
            end else if (is_int_tag(tag) || tag == TAG_REFRTM) begin
              iacc = {iacc[55:0], byte_in};
            end
          end
          if (rem[lvl + 2'd1] == 32'd0) begin
            ld = 1'b1;
            ph = PH_TAG;
          end
        end
        default: ;
      endcase

      if (hd) begin
        tag = tags[lvl];
        if (lacc > rem[lvl]) begin
          if (ev_n < 3'd6) begin
            evs[ev_n] = mk_ev(K_OVERRUN, acnt, tag, {32'd0, rem[lvl]}, lacc);
            ev_n = ev_n + 3'd1;
          end
          ph = PH_SKIP;
        end else begin
          rem[lvl + 2'd1] = lacc;
          iacc = '0;
          ph   = PH_CONTENT;
          if (lvl == 2'd0 && tag == TAG_SEQASDU) begin
            lvl = 2'd1;
            ph  = PH_TAG;
          end else if (lvl == 2'd1 && tag == TAG_ASDU) begin
            if (ev_n < 3'd6) begin
              evs[ev_n] = mk_ev(K_ASDU, acnt, tag, 64'd0, lacc);
              ev_n = ev_n + 3'd1;
            end
            lvl = 2'd2;
            ph  = PH_TAG;
          end else begin
            if (lvl == 2'd0) begin
              if (tag == TAG_NOASDU) begin
                if ((lacc == 32'd0 || lacc > 32'd8) && ev_n < 3'd6) begin
                  evs[ev_n] = mk_ev(K_BADINT, acnt, tag, 64'd0, lacc);
                  ev_n = ev_n + 3'd1;
                end
              end else if (ev_n < 3'd6) begin
                evs[ev_n] = mk_ev(K_UNKPDU, acnt, tag, 64'd0, lacc);
                ev_n = ev_n + 3'd1;
              end
            end else if (lvl == 2'd1) begin
              if (ev_n < 3'd6) begin
                evs[ev_n] = mk_ev(K_NOTSEQ, acnt, tag, 64'd0, lacc);
                ev_n = ev_n + 3'd1;
              end
            end else begin
              if (is_int_tag(tag)) begin
                if ((lacc == 32'd0 || lacc > 32'd8) && ev_n < 3'd6) begin
                  evs[ev_n] = mk_ev(K_BADINT, acnt, tag, 64'd0, lacc);
                  ev_n = ev_n + 3'd1;
                end
              end else if (tag == TAG_REFRTM) begin
                if (lacc != 32'd8 && ev_n < 3'd6) begin
                  evs[ev_n] = mk_ev(K_BADREFR, acnt, tag, 64'd0, lacc);
                  ev_n = ev_n + 3'd1;
                end
              end else if (tag == TAG_GMID) begin
                if (lacc != 32'd8 && ev_n < 3'd6) begin
                  evs[ev_n] = mk_ev(K_BADGMID, acnt, tag, 64'd0, lacc);
                  ev_n = ev_n + 3'd1;
                end
              end else if (tag != TAG_SVID && tag != TAG_DATSET && tag != TAG_SEQDATA) begin
                if (ev_n < 3'd6) begin
                  evs[ev_n] = mk_ev(K_UNKASDU, acnt, tag, 64'd0, lacc);
                  ev_n = ev_n + 3'd1;
                end
              end
            end
            if (lacc == 32'd0) begin
              ld = 1'b1;
              ph = PH_TAG;
            end
          end
        end
      end

      if (ld) begin
        tag = tags[lvl];
        v   = iacc;
        if ((lvl == 2'd0 && tag == TAG_NOASDU) || (lvl == 2'd2 && is_int_tag(tag))) begin
          if (lacc != 32'd0 && lacc <= 32'd8) begin
            for (int j = 1; j < 8; j++) begin
              if (lacc[3:0] == 4'(j) && v[j*8-1]) v = v | ~((64'd1 << (j*8)) - 64'd1);
            end
            if (lvl == 2'd0) begin
              dac = v;
              if (ev_n < 3'd6) begin
                evs[ev_n] = mk_ev(K_NOASDU, acnt, tag, v, lacc);
                ev_n = ev_n + 3'd1;
              end
            end else if (ev_n < 3'd6) begin
              evs[ev_n] = mk_ev((tag == TAG_SMPCNT) ? K_SMPCNT :
                                (tag == TAG_CONFREV) ? K_CONFREV :
                                (tag == TAG_SMPSYNCH) ? K_SMPSYNCH :
                                (tag == TAG_SMPRATE) ? K_SMPRATE : K_SMPMOD,
                                acnt, tag, v, lacc);
              ev_n = ev_n + 3'd1;
            end
          end
        end else if (lvl == 2'd2 && tag == TAG_REFRTM && lacc == 32'd8) begin
          if (ev_n < 3'd6) begin
            evs[ev_n] = mk_ev(K_SECONDS, acnt, tag, {32'd0, v[63:32]}, lacc);
            ev_n = ev_n + 3'd1;
          end
          // fraction only; the back end scales it to nanoseconds
          if (ev_n < 3'd6) begin
            evs[ev_n] = mk_ev(K_NSEC, acnt, tag, {40'd0, v[31:8]}, lacc);
            ev_n = ev_n + 3'd1;
          end
          if (ev_n < 3'd6) begin
            evs[ev_n] = mk_ev(K_QUALITY, acnt, tag, {56'd0, v[7:0]}, lacc);
            ev_n = ev_n + 3'd1;
          end
        end
      end
    end

    if (acc_go || body_go) begin
      for (int it = 0; it < 4; it++) begin
        if (!sdone) begin
          if (ph == PH_TAG) begin
            if (rem[lvl] < 32'd2) begin
              ph = PH_SKIP;
            end else if (lvl == 2'd1 && acnt >= capv) begin
              if (ev_n < 3'd6) begin
                evs[ev_n] = mk_ev(K_CAP, acnt, TAG_SEQASDU, {56'd0, capv}, 32'd0);
                ev_n = ev_n + 3'd1;
              end
              ph = PH_SKIP;
            end else begin
              sdone = 1'b1;
            end
          end
          if (!sdone) begin
            if (ph != PH_SKIP || rem[lvl] != 32'd0) begin
              sdone = 1'b1;
            end else if (lvl == 2'd0) begin
              if (dac != {56'd0, acnt} && ev_n < 3'd6) begin
                evs[ev_n] = mk_ev(K_MISMATCH, acnt, TAG_NOASDU, dac, {24'd0, acnt});
                ev_n = ev_n + 3'd1;
              end
              ph    = PH_AFTER;
              sdone = 1'b1;
            end else begin
              if (lvl == 2'd2 && acnt != 8'd255) acnt = acnt + 8'd1;
              lvl = lvl - 2'd1;
              ph  = PH_TAG;
            end
          end
        end
      end
    end

    if (pos != 16'hFFFF) pos = pos + 16'd1;

    if (last_in) begin
      if (ph == PH_HEADER || ph == PH_ALEN) begin
        if (ev_n < 3'd6) begin
          evs[ev_n] = mk_ev(K_REJECT, acnt, 8'h00, RJ_EARLY_END, 32'd0);
          ev_n = ev_n + 3'd1;
        end
        ph = PH_REJECT;
      end
      if (ph == PH_AFTER && re >= aend) trail = {48'd0, re - aend};
      if (ev_n < 3'd6) begin
        evs[ev_n] = mk_ev(K_END, acnt, 8'h00, trail, 32'd0);
        ev_n = ev_n + 3'd1;
      end
      ph = PH_HEADER; pos = '0; dl = '0; re = '0; appid = '0; aend = '0;
      rem = '{default: '0}; tags = '{default: '0}; lacc = '0; lbl = '0;
      iacc = '0; acnt = '0; dac = '0; sim = 1'b0; impl = 1'b0; lvl = '0;
    end

    if (ev_n != 3'd0) evs[ev_n - 3'd1].last = 1'b1;
  end

  assign step_valid = accept && (ev_n != 3'd0);
  assign step.count = ev_n;
  assign step.ev    = evs;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_asdus_r <= SVFP_CAP_DEFAULT;
    end else if (cfg_we) begin
      max_asdus_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= PH_HEADER; pos_r <= '0; dl_r <= '0; re_r <= '0; appid_r <= '0;
      aend_r <= '0; rem_r <= '{default: '0}; tags_r <= '{default: '0};
      lacc_r <= '0; lbl_r <= '0; iacc_r <= '0; acnt_r <= '0; dac_r <= '0;
      sim_r <= 1'b0; impl_r <= 1'b0; lvl_r <= '0;
    end else if (accept) begin
      ph_r <= ph; pos_r <= pos; dl_r <= dl; re_r <= re; appid_r <= appid;
      aend_r <= aend; rem_r <= rem; tags_r <= tags; lacc_r <= lacc;
      lbl_r <= lbl; iacc_r <= iacc; acnt_r <= acnt; dac_r <= dac;
      sim_r <= sim; impl_r <= impl; lvl_r <= lvl;
    end
  end

endmodule

FILE: hdl/svfp_step_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sampled values frame parser step queue
// Short queue of per-byte event groups between front and back end.
// ----------------------------------------------------------------------------
module svfp_step_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  svfp_pkg::step_t     wdata,
  input  logic                pop,
  output logic                full,
  output svfp_pkg::q_head_t   head
);
  import svfp_pkg::*;

  localparam int PtrW = (SVFP_Q_DEPTH > 1) ? $clog2(SVFP_Q_DEPTH) : 1;
  localparam int CntW = $clog2(SVFP_Q_DEPTH + 1);

  step_t           slot_r [SVFP_Q_DEPTH];
  logic [PtrW-1:0] wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;

  assign full       = (cnt_r == CntW'(SVFP_Q_DEPTH));
  assign head.valid = (cnt_r != '0);
  assign head.head  = slot_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (push) begin
      wptr_nxt = (wptr_r == PtrW'(SVFP_Q_DEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (pop) begin
      rptr_nxt = (rptr_r == PtrW'(SVFP_Q_DEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    else if (pop && !push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wptr_r] <= wdata;
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push)
    else $error("item pushed into full step queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head.valid)
    else $error("step queue popped while empty");
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CntW'(SVFP_Q_DEPTH))
    else $error("step queue count out of range");
  a_cnt_track: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> cnt_r == $past(cnt_r) + 1'b1)
    else $error("step queue count missed a push");
`endif

endmodule

FILE: hdl/svfp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sampled values frame parser back end
// Serialises queued events, scales refrTm fraction, drives result register.
// ----------------------------------------------------------------------------
module svfp_back (
  input  logic                clk,
  input  logic                rst_n,
  input  svfp_pkg::q_head_t   head,
  output logic                q_pop,
  input  logic                out_pop,
  output logic                out_empty,
  output svfp_pkg::event_t    out_ev
);
  import svfp_pkg::*;

  logic [2:0]  idx_r, idx_nxt;
  logic        ovalid_r, ovalid_nxt;
  event_t      oev_r, oev_nxt, cur;
  logic        take, last_ev;
  logic [53:0] ns_prod;

  assign cur     = head.head.ev[idx_r];
  assign take    = head.valid && (!ovalid_r || out_pop);
  assign last_ev = (idx_r == head.head.count - 3'd1);
  assign q_pop   = take && last_ev;
  assign ns_prod = cur.value[23:0] * SVFP_NS_PER_S;

  always_comb begin
    idx_nxt    = idx_r;
    ovalid_nxt = ovalid_r;
    oev_nxt    = oev_r;
    if (take) begin
      idx_nxt    = last_ev ? 3'd0 : idx_r + 3'd1;
      ovalid_nxt = 1'b1;
      oev_nxt    = cur;
      if (cur.kind == K_NSEC) oev_nxt.value = {34'd0, ns_prod[53:24]};
    end else if (out_pop) begin
      ovalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r    <= '0;
      ovalid_r <= 1'b0;
    end else begin
      idx_r    <= idx_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    oev_r <= oev_nxt;
  end

  assign out_empty = !ovalid_r;
  assign out_ev    = oev_r;

endmodule
